// ----- sv/thne_pkg.sv -----
package thne_pkg;

	localparam int unsigned CharW   = 16;
	localparam int unsigned QDepth  = 4;
	localparam int unsigned QAddrW  = $clog2(QDepth);
	localparam int unsigned QCountW = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] CHAR_TILDE = 16'h007E;
	localparam logic [CharW-1:0] CHAR_SPACE = 16'h0020;
	localparam logic [CharW-1:0] CHAR_DOT   = 16'h002E;
	localparam logic [CharW-1:0] CHAR_QUOTE = 16'h0022;
	localparam logic [CharW-1:0] CHAR_STAR  = 16'h002A;
	localparam logic [CharW-1:0] CHAR_SLASH = 16'h002F;
	localparam logic [CharW-1:0] CHAR_COLON = 16'h003A;
	localparam logic [CharW-1:0] CHAR_LESS  = 16'h003C;
	localparam logic [CharW-1:0] CHAR_MORE  = 16'h003E;
	localparam logic [CharW-1:0] CHAR_QMARK = 16'h003F;
	localparam logic [CharW-1:0] CHAR_BSLSH = 16'h005C;
	localparam logic [CharW-1:0] CHAR_BAR   = 16'h007C;

	// escape sequence: tilde, high digit, low digit, tilde
	typedef enum logic [1:0] {
		STEP_OPEN  = 2'd0,
		STEP_HI    = 2'd1,
		STEP_LO    = 2'd2,
		STEP_CLOSE = 2'd3
	} thne_step_t;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             esc;
		logic             last;
	} thne_entry_t;

	function automatic logic is_reserved(input logic [CharW-1:0] c);
		logic r;
		r = 1'b0;
		if (c < CHAR_SPACE) r = 1'b1;
		if (c == CHAR_QUOTE || c == CHAR_STAR || c == CHAR_SLASH || c == CHAR_COLON
			|| c == CHAR_LESS || c == CHAR_MORE || c == CHAR_QMARK
			|| c == CHAR_BSLSH || c == CHAR_BAR) r = 1'b1;
		return r;
	endfunction

	// lower-case hex digit as a character code
	function automatic logic [CharW-1:0] hex_char(input logic [3:0] n);
		logic [CharW-1:0] r;
		if (n < 4'd10) r = 16'h0030 + {12'd0, n};
		else r = 16'h0057 + {12'd0, n};
		return r;
	endfunction

endpackage

// ----- sv/thne_ifs.sv -----
interface thne_in_if;
	import thne_pkg::*;
	logic             valid;
	logic             ready;
	logic [CharW-1:0] in_char;
	logic             in_last;
	modport source (output valid, in_char, in_last, input ready);
	modport sink (input valid, in_char, in_last, output ready);
endinterface

interface thne_out_if;
	import thne_pkg::*;
	logic             valid;
	logic             ready;
	logic [CharW-1:0] out_char;
	logic             run_last;
	logic             name_end;
	modport source (output valid, out_char, run_last, name_end, input ready);
	modport sink (input valid, out_char, run_last, name_end, output ready);
endinterface

interface thne_cfg_if;
	logic valid;
	logic ready;
	logic folder_mode;
	modport source (output valid, folder_mode, input ready);
	modport sink (input valid, folder_mode, output ready);
endinterface

// ----- sv/tilde_hex_name_escaper.sv -----
// channel   dir   payload                           accepted when
// in_ch     in    in_char[15:0], in_last            valid && ready
// out_ch    out   out_char[15:0], run_last, name_end valid && ready
// cfg_ch    in    folder_mode                       valid && ready (ready tied high)
//
// one output word per cycle from the back end's output register while out_ch.ready
// holds and entries wait: a plain character gives one word, an escaped one four (tilde, two hex digits, tilde)
// an input word passes through the queue, the back end's current-entry register and the output register
// reset empties the queue (pointers and count) and clears valids; folder_mode to 0, name start flag to 1
// input and output stall on their own: the four-entry queue keeps taking words
// while the output waits, and in_ch.ready drops only when the queue is full
module tilde_hex_name_escaper
	import thne_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	thne_in_if.sink    in_ch,
	thne_out_if.source out_ch,
	thne_cfg_if.sink   cfg_ch
);

	// front to queue
	logic        push;
	thne_entry_t push_entry;
	logic        q_full;
	// queue to back
	logic        pop_req;
	logic        q_avail;
	thne_entry_t q_head;

	// front: handshake, escape decision, name start tracking, config register
	thne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg_ch     (cfg_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// classified words waiting for the back end
	thne_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop_req    (pop_req),
		.avail      (q_avail),
		.head       (q_head)
	);

	// back: expands each entry into one or four output words
	thne_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_head  (q_head),
		.pop_req (pop_req),
		.out_ch  (out_ch)
	);

endmodule

// ----- sv/thne_front.sv -----
module thne_front
	import thne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	thne_in_if.sink     in_ch,
	thne_cfg_if.sink    cfg_ch,
	input  logic        q_full,
	output logic        push,
	output thne_entry_t push_entry
);

	logic folder_mode_q;
	logic at_name_start_q;
	logic esc;
	logic accept;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !q_full;
	assign accept       = in_ch.valid && !q_full;

	always_comb begin
		esc = is_reserved(in_ch.in_char);
		if (at_name_start_q && in_ch.in_char == CHAR_SPACE) esc = 1'b1;
		if (folder_mode_q && in_ch.in_last
			&& (in_ch.in_char == CHAR_DOT || in_ch.in_char == CHAR_SPACE)) esc = 1'b1;
	end

	assign push            = accept;
	assign push_entry.ch   = in_ch.in_char;
	assign push_entry.esc  = esc;
	assign push_entry.last = in_ch.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			folder_mode_q   <= 1'b0;
			at_name_start_q <= 1'b1;
		end else begin
			if (cfg_ch.valid) folder_mode_q <= cfg_ch.folder_mode;
			if (accept) at_name_start_q <= in_ch.in_last;
		end
	end

endmodule

// ----- sv/thne_queue.sv -----
module thne_queue
	import thne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  thne_entry_t push_entry,
	output logic        full,
	input  logic        pop_req,
	output logic        avail,
	output thne_entry_t head
);

	thne_entry_t        mem_q [QDepth];
	logic [QAddrW-1:0]  wr_ptr_q;
	logic [QAddrW-1:0]  rd_ptr_q;
	logic [QCountW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = count_q == QCountW'(QDepth);
	assign avail   = count_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop_req && avail;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- sv/thne_back.sv -----
module thne_back
	import thne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_avail,
	input  thne_entry_t q_head,
	output logic        pop_req,
	thne_out_if.source  out_ch
);

	logic             cur_vld_q;
	thne_entry_t      cur_q;
	thne_step_t       step_q;
	logic             out_vld_q;
	logic [CharW-1:0] out_char_q;
	logic             run_last_q;
	logic             name_end_q;
	logic             adv;
	logic             fin;
	logic             take;
	logic [CharW-1:0] word;

	assign adv     = cur_vld_q && (!out_vld_q || out_ch.ready);
	assign fin     = !cur_q.esc || step_q == STEP_CLOSE;
	assign take    = !cur_vld_q || (adv && fin);
	assign pop_req = take;

	always_comb begin
		if (!cur_q.esc) begin
			word = cur_q.ch;
		end else begin
			unique case (step_q)
				STEP_HI: word = hex_char(cur_q.ch[7:4]);
				STEP_LO: word = hex_char(cur_q.ch[3:0]);
				default: word = CHAR_TILDE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			step_q    <= STEP_OPEN;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				cur_vld_q <= q_avail;
				step_q    <= STEP_OPEN;
			end else if (adv) begin
				step_q <= thne_step_t'(step_q + 2'd1);
			end
			if (adv) out_vld_q <= 1'b1;
			else if (out_ch.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= q_head;
		if (adv) begin
			out_char_q <= word;
			run_last_q <= fin;
			name_end_q <= fin && cur_q.last;
		end
	end

	assign out_ch.valid    = out_vld_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.run_last = run_last_q;
	assign out_ch.name_end = name_end_q;

endmodule

// ----- sv/thne_checker.sv -----
module thne_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_char,
	input logic        run_last,
	input logic        name_end
);

	// a stalled word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// an escape sequence continues without a gap once started
	a_esc_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside escape sequence");

	// end of name is always the end of an item
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_end |-> run_last)
		else $error("name_end without run_last");

	// words inside an escape are tilde or lower-case hex digits
	a_esc_chars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> (out_char == 16'h007E
			|| (out_char >= 16'h0030 && out_char <= 16'h0039)
			|| (out_char >= 16'h0061 && out_char <= 16'h0066)))
		else $error("bad character inside escape sequence");

endmodule

bind tilde_hex_name_escaper thne_checker u_thne_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.run_last  (out_ch.run_last),
	.name_end  (out_ch.name_end)
);

// ----- bench/tilde_hex_name_escaper_tb.sv -----
`timescale 1ns / 100ps

module tilde_hex_name_escaper_tb;
	import thne_pkg::*;

	// quiet cycles before a folder_mode write, enough to cover the pipe
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_IDLE = 18;
	localparam int unsigned RANDOM_CHARS = 120;
	localparam int unsigned RANDOM_PHASES = 6;

	typedef enum logic {
		FEED_CHAR,
		FEED_MODE
	} feed_kind_t;

	// one entry of the stimulus queue: a title character or a folder_mode write
	typedef struct {
		feed_kind_t       kind;
		logic [CharW-1:0] ch;
		logic             last;
		logic             folder;
		logic             calm;
		int unsigned      gap;
	} feed_t;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             run_last;
		logic             name_end;
	} out_word_t;

	logic clk;
	logic arst_n;

	thne_in_if  in_ch();
	thne_out_if out_ch();
	thne_cfg_if cfg_ch();

	tilde_hex_name_escaper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// characters that are always escaped besides the control codes
	logic [CharW-1:0] forbidden_set [9] = '{CHAR_QUOTE, CHAR_STAR, CHAR_SLASH,
		CHAR_COLON, CHAR_LESS, CHAR_MORE, CHAR_QMARK, CHAR_BSLSH, CHAR_BAR};

	feed_t       title_feed [$];   // characters and mode writes still to drive
	out_word_t   escaped_due [$];  // output words predicted but not yet seen
	int unsigned mismatches = 0;

	// bench copy of the block state
	logic        folder_now;
	logic        name_start;

	// set while filling the feed, and per phase for the output side
	logic        fill_calm = 1'b0;
	logic        rx_calm = 1'b0;

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned draw_idle();
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, MAX_IDLE);
	endfunction

	function automatic logic always_escaped(input logic [CharW-1:0] c);
		if (c < CHAR_SPACE) return 1'b1;
		case (c)
			CHAR_QUOTE, CHAR_STAR, CHAR_SLASH, CHAR_COLON, CHAR_LESS,
			CHAR_MORE, CHAR_QMARK, CHAR_BSLSH, CHAR_BAR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// lower-case hex digit of one nibble, as a 16-bit character
	function automatic logic [CharW-1:0] nibble_digit(input logic [3:0] n);
		logic [7:0] code;
		code = (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
		return {8'h00, code};
	endfunction

	// predicted escaping of one accepted word, updates the name start flag
	task automatic predict_escape(input logic [CharW-1:0] c, input logic last);
		logic esc;
		esc = always_escaped(c);
		if (name_start && c == CHAR_SPACE) esc = 1'b1;
		if (folder_now && last && (c == CHAR_DOT || c == CHAR_SPACE)) esc = 1'b1;
		name_start = last;
		if (!esc) begin
			escaped_due.push_back('{c, 1'b1, last});
		end else begin
			escaped_due.push_back('{CHAR_TILDE, 1'b0, 1'b0});
			escaped_due.push_back('{nibble_digit(c[7:4]), 1'b0, 1'b0});
			escaped_due.push_back('{nibble_digit(c[3:0]), 1'b0, 1'b0});
			escaped_due.push_back('{CHAR_TILDE, 1'b1, last});
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic add_char(input logic [CharW-1:0] c, input logic last);
		feed_t f;
		f.kind = FEED_CHAR;
		f.ch = c;
		f.last = last;
		f.folder = 1'b0;
		f.calm = 1'b0;
		f.gap = fill_calm ? 0 : draw_idle();
		title_feed.push_back(f);
	endtask

	// folder_mode write; calm means no idling on either side in the next phase
	task automatic add_mode(input logic folder, input logic calm);
		feed_t f;
		f.kind = FEED_MODE;
		f.ch = '0;
		f.last = 1'b0;
		f.folder = folder;
		f.calm = calm;
		f.gap = 0;
		fill_calm = calm;
		title_feed.push_back(f);
	endtask

	// mix of escaped, borderline and plain characters plus full 16-bit noise
	function automatic logic [CharW-1:0] pick_char();
		case ($urandom_range(0, 9))
			0: return forbidden_set[$urandom_range(0, 8)];
			1: return CHAR_SPACE;
			2: return CHAR_DOT;
			3: return CharW'($urandom_range(0, 31));
			4, 5: return CharW'($urandom_range(0, 65535));
			default: return CharW'($urandom_range(33, 127));
		endcase
	endfunction

	// driver: presents queued words and mode writes, one assignment per signal
	always @(posedge clk or negedge arst_n) begin
		feed_t            head;
		logic             in_busy;
		logic             cfg_busy;
		logic [CharW-1:0] ch_next;
		logic             last_next;
		logic             fold_next;
		int unsigned      waited;
		int unsigned      quiet;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.in_char <= '0;
			in_ch.in_last <= 1'b0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.folder_mode <= 1'b0;
			folder_now = 1'b0;
			name_start = 1'b1;
			waited = 0;
			quiet = 0;
		end else begin
			in_busy = in_ch.valid;
			cfg_busy = cfg_ch.valid;
			ch_next = in_ch.in_char;
			last_next = in_ch.in_last;
			fold_next = cfg_ch.folder_mode;

			if (in_ch.valid && in_ch.ready) begin
				predict_escape(in_ch.in_char, in_ch.in_last);
				in_busy = 1'b0;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				folder_now = cfg_ch.folder_mode;
				cfg_busy = 1'b0;
			end

			// count cycles with nothing in flight, mode writes wait for enough of them
			if (escaped_due.size() == 0 && !in_ch.valid) quiet++;
			else quiet = 0;

			if (!in_busy && !cfg_busy && title_feed.size() > 0) begin
				head = title_feed[0];
				if (waited < head.gap) begin
					waited++;
				end else if (head.kind == FEED_CHAR) begin
					ch_next = head.ch;
					last_next = head.last;
					in_busy = 1'b1;
					void'(title_feed.pop_front());
					waited = 0;
				end else if (quiet >= SETTLE_CYCLES) begin
					fold_next = head.folder;
					rx_calm = head.calm;
					cfg_busy = 1'b1;
					void'(title_feed.pop_front());
					waited = 0;
				end
			end

			in_ch.valid <= in_busy;
			in_ch.in_char <= ch_next;
			in_ch.in_last <= last_next;
			cfg_ch.valid <= cfg_busy;
			cfg_ch.folder_mode <= fold_next;
		end
	end

	// monitor: stalls the output at random, checks each word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		out_word_t   got;
		out_word_t   want;
		int unsigned rx_hold;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_hold = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.out_char, out_ch.run_last, out_ch.name_end};
				if (escaped_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h run_last %b name_end %b",
						got.ch, got.run_last, got.name_end));
				end else begin
					want = escaped_due.pop_front();
					if (got.ch != want.ch)
						report_mismatch($sformatf("out_char %h, expected %h", got.ch, want.ch));
					if (got.run_last != want.run_last)
						report_mismatch($sformatf("run_last %b, expected %b on char %h",
							got.run_last, want.run_last, want.ch));
					if (got.name_end != want.name_end)
						report_mismatch($sformatf("name_end %b, expected %b on char %h",
							got.name_end, want.name_end, want.ch));
				end
				rx_hold = rx_calm ? 0 : draw_idle();
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			out_ch.ready <= (rx_hold == 0);
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned sent;
		int unsigned len;
		arst_n = 1'b0;

		// plain mode: leading space, inner space, trailing dot left alone
		add_mode(1'b0, 1'b0);
		add_char(CHAR_SPACE, 1'b0);
		add_char(16'h0061, 1'b0);
		add_char(CHAR_SPACE, 1'b0);
		add_char(CHAR_DOT, 1'b1);
		// field extremes, control codes, every forbidden character, trailing space
		add_char(16'h0000, 1'b0);
		add_char(16'hFFFF, 1'b0);
		add_char(16'h001F, 1'b0);
		for (int i = 0; i < 9; i++) add_char(forbidden_set[i], 1'b0);
		add_char(CHAR_TILDE, 1'b0);
		add_char(16'h8000, 1'b0);
		add_char(CHAR_SPACE, 1'b1);
		// single-space name, first-space rule only
		add_char(CHAR_SPACE, 1'b1);

		// folder mode: single space hits both rules, escaped once
		add_mode(1'b1, 1'b0);
		add_char(CHAR_SPACE, 1'b1);
		add_char(16'h0061, 1'b0);
		add_char(CHAR_DOT, 1'b1);
		add_char(CHAR_DOT, 1'b1);
		add_char(16'h0062, 1'b0);
		add_char(CHAR_SPACE, 1'b1);

		// random names over several mode settings, one phase without idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			add_mode(p[0], p == 3);
			sent = 0;
			while (sent < RANDOM_CHARS / RANDOM_PHASES) begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) add_char(pick_char(), k == len - 1);
				sent += len;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: everything driven and every predicted word seen
		while (title_feed.size() > 0 || in_ch.valid || cfg_ch.valid || escaped_due.size() > 0)
			@(negedge clk);
		// keep the clock running to catch stray words
		repeat (4 * SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
